[rtl/lhtlp_pkg.sv]
// Shared constants for the label hash table: status and op codes, default sizes, capacity width and reset.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps
`default_nettype none
package lhtlp_pkg;

   localparam int TABLE_DEPTH_DEF = 256;
   localparam int LABEL_CHARS_DEF = 32;
   localparam int DATA_BITS_DEF   = 32;

   localparam int CAP_BITS  = 9;
   localparam int CAP_RESET = 256;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FULL      = 3'd2;
   localparam logic [2:0] ST_FOUND     = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_FIND   = 1'b1;

endpackage
`default_nettype wire

[rtl/label_hash_table_linear_probe.sv]
// Top level of the label hash table: front end, command queue, back end.
// Depends on lhtlp_pkg, lhtlp_front, lhtlp_queue, lhtlp_back.
//
//   channel | direction | handshake              | payload
//   req     | in        | req_valid / req_ready  | op, label_byte, label_last, entry_data
//   rsp     | out       | rsp_valid / rsp_ready  | status, slot_index
//   csr     | in        | csr_write_enable       | capacity_in_use (9 bits)
//
// A label byte is taken in one cycle; bytes stall while the queue holds two commands.
// In the back end a command runs a remainder step per hash bit, then a READ and
// a CHECK state for each slot probed.
// Synchronous reset clears all slot valid bits at once; no clearing pass.
// A result held by rsp_ready stalls the back end; the queue absorbs two commands.
`timescale 1ns / 1ps
`default_nettype none
module label_hash_table_linear_probe #(
   parameter int TABLE_DEPTH = lhtlp_pkg::TABLE_DEPTH_DEF,
   parameter int LABEL_CHARS = lhtlp_pkg::LABEL_CHARS_DEF,
   parameter int DATA_BITS   = lhtlp_pkg::DATA_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic                           req_op,
   input  logic [7:0]                     req_label_byte,
   input  logic                           req_label_last,
   input  logic [DATA_BITS-1:0]           req_entry_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_status,
   output logic [7:0]                     rsp_slot_index,
   input  logic                           csr_write_enable,
   input  logic [lhtlp_pkg::CAP_BITS-1:0] csr_write_data
);
   import lhtlp_pkg::*;

   localparam int CMD_W = 1 + 32 + $clog2(LABEL_CHARS + 1) + LABEL_CHARS * 8 + DATA_BITS;

   logic             fq_valid;
   logic             fq_ready;
   logic [CMD_W-1:0] fq_data;
   logic             qb_valid;
   logic             qb_ready;
   logic [CMD_W-1:0] qb_data;

   lhtlp_front #(.LABEL_CHARS(LABEL_CHARS), .DATA_BITS(DATA_BITS), .CMD_W(CMD_W)) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_op         (req_op),
      .req_label_byte (req_label_byte),
      .req_label_last (req_label_last),
      .req_entry_data (req_entry_data),
      .cmd_valid      (fq_valid),
      .cmd_ready      (fq_ready),
      .cmd_data       (fq_data)
   );

   lhtlp_queue #(.WIDTH(CMD_W)) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (fq_valid),
      .push_ready (fq_ready),
      .push_data  (fq_data),
      .pop_valid  (qb_valid),
      .pop_ready  (qb_ready),
      .pop_data   (qb_data)
   );

   lhtlp_back #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .LABEL_CHARS (LABEL_CHARS),
      .DATA_BITS   (DATA_BITS),
      .CMD_W       (CMD_W)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .cmd_valid        (qb_valid),
      .cmd_ready        (qb_ready),
      .cmd_data         (qb_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_slot_index   (rsp_slot_index)
   );

endmodule
`default_nettype wire

[rtl/lhtlp_front.sv]
// Front end: takes label bytes, keeps the running hash and label buffer, and emits
// one command word per last byte. Depends on lhtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhtlp_front #(
   parameter int LABEL_CHARS = lhtlp_pkg::LABEL_CHARS_DEF,
   parameter int DATA_BITS   = lhtlp_pkg::DATA_BITS_DEF,
   parameter int CMD_W       = 1 + 32 + $clog2(LABEL_CHARS + 1) + LABEL_CHARS * 8 + DATA_BITS
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_op,
   input  logic [7:0]           req_label_byte,
   input  logic                 req_label_last,
   input  logic [DATA_BITS-1:0] req_entry_data,
   output logic                 cmd_valid,
   input  logic                 cmd_ready,
   output logic [CMD_W-1:0]     cmd_data
);
   import lhtlp_pkg::*;

   localparam int LEN_W  = $clog2(LABEL_CHARS + 1);
   localparam int BIDX_W = $clog2(LABEL_CHARS);

   logic [7:0]                 label_ff [LABEL_CHARS];
   logic [LEN_W-1:0]           len_ff;
   logic [LEN_W-1:0]           len_in;
   logic [31:0]                hash_ff;
   logic [31:0]                hash_in;
   logic [LABEL_CHARS*8-1:0]   label_flat;
   logic                       room;
   logic                       accept;

   assign req_ready = cmd_ready;
   assign accept    = req_valid & req_ready;
   assign room      = len_ff < LEN_W'(LABEL_CHARS);
   assign cmd_valid = req_valid & req_label_last;

   always_comb begin
      // h*7 + byte, wrapping at 32 bits
      hash_in = room ? (hash_ff << 3) - hash_ff + {24'b0, req_label_byte} : hash_ff;
      len_in  = room ? len_ff + LEN_W'(1) : len_ff;
      for (int i = 0; i < LABEL_CHARS; i++) begin
         label_flat[i*8 +: 8] = (room && len_ff[BIDX_W-1:0] == BIDX_W'(i)) ?
                                req_label_byte : label_ff[i];
      end
   end

   assign cmd_data = {req_op, hash_in, len_in, label_flat, req_entry_data};

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff  <= '0;
         hash_ff <= '0;
      end else if (accept) begin
         len_ff  <= req_label_last ? '0 : len_in;
         hash_ff <= req_label_last ? '0 : hash_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && room) begin
         label_ff[len_ff[BIDX_W-1:0]] <= req_label_byte;
      end
   end

endmodule
`default_nettype wire

[rtl/lhtlp_queue.sv]
// Two-entry command queue between front and back end.
// Depends on lhtlp_pkg only through the common import convention.
`timescale 1ns / 1ps
`default_nettype none
module lhtlp_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);
   import lhtlp_pkg::*;

   logic [WIDTH-1:0] entry_ff [2];
   logic [1:0]       count_ff;
   logic             wr_ff;
   logic             rd_ff;
   logic             push;
   logic             pop;

   assign push_ready = count_ff != 2'd2;
   assign pop_valid  = count_ff != 2'd0;
   assign pop_data   = entry_ff[rd_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
      end else begin
         if (push) wr_ff <= ~wr_ff;
         if (pop) rd_ff <= ~rd_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end

   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ff] <= push_data;
   end

endmodule
`default_nettype wire

[rtl/lhtlp_back.sv]
// Back end: reduces the hash modulo the capacity one bit a cycle, then probes the
// slot table linearly, a READ and a CHECK state a slot. Holds the capacity register. Uses lhtlp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module lhtlp_back #(
   parameter int TABLE_DEPTH = lhtlp_pkg::TABLE_DEPTH_DEF,
   parameter int LABEL_CHARS = lhtlp_pkg::LABEL_CHARS_DEF,
   parameter int DATA_BITS   = lhtlp_pkg::DATA_BITS_DEF,
   parameter int CMD_W       = 1 + 32 + $clog2(LABEL_CHARS + 1) + LABEL_CHARS * 8 + DATA_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_enable,
   input  logic [lhtlp_pkg::CAP_BITS-1:0] csr_write_data,
   input  logic                          cmd_valid,
   output logic                          cmd_ready,
   input  logic [CMD_W-1:0]              cmd_data,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [2:0]                    rsp_status,
   output logic [7:0]                    rsp_slot_index
);
   import lhtlp_pkg::*;

   localparam int LEN_W = $clog2(LABEL_CHARS + 1);
   localparam int LBL_W = LABEL_CHARS * 8;
   localparam int ROW_W = LEN_W + LBL_W;
   localparam int CAP_W = $clog2(TABLE_DEPTH + 1);
   localparam int IDX_W = $clog2(TABLE_DEPTH);

   typedef enum logic [1:0] {IDLE, DIV, READ, CHECK} state_type;

   state_type             state_ff;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [CAP_W-1:0]      cap_eff;
   logic                  op_ff;
   logic [31:0]           hash_ff;
   logic [LEN_W-1:0]      len_ff;
   logic [LBL_W-1:0]      label_ff;
   logic [DATA_BITS-1:0]  data_ff;
   logic [CAP_W-1:0]      rem_ff;
   logic [CAP_W:0]        rem_shift;
   logic [CAP_W-1:0]      rem_in;
   logic [4:0]            bit_ff;
   logic [IDX_W-1:0]      pos_ff;
   logic [CAP_W-1:0]      pos_inc;
   logic [IDX_W-1:0]      pos_in;
   logic [CAP_W-1:0]      probe_ff;
   logic [CAP_W-1:0]      probe_in;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                  valid_q;
   logic [ROW_W-1:0]      row_mem [TABLE_DEPTH];
   logic [DATA_BITS-1:0]  data_mem [TABLE_DEPTH];
   logic [ROW_W-1:0]      row_q;
   logic                  match;
   logic                  store;
   logic                  rsp_valid_ff;
   logic [2:0]            status_ff;
   logic [7:0]            slot_ff;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_slot_index = slot_ff;
   assign cmd_ready      = (state_ff == IDLE) && !rsp_valid_ff;

   always_comb begin
      if (cap_ff == '0) begin
         cap_eff = CAP_W'(1);
      end else if (int'(cap_ff) > TABLE_DEPTH) begin
         cap_eff = CAP_W'(TABLE_DEPTH);
      end else begin
         cap_eff = CAP_W'(cap_ff);
      end
   end

   // restoring remainder step: one hash bit per cycle, MSB first
   always_comb begin
      rem_shift = {rem_ff, hash_ff[31]};
      rem_in    = (rem_shift >= {1'b0, cap_eff}) ? CAP_W'(rem_shift - {1'b0, cap_eff}) :
                                                   CAP_W'(rem_shift);
   end

   always_comb begin
      pos_inc  = CAP_W'(pos_ff) + CAP_W'(1);
      pos_in   = (pos_inc == cap_eff) ? '0 : IDX_W'(pos_inc);
      probe_in = probe_ff + CAP_W'(1);
   end

   always_comb begin
      match = row_q[ROW_W-1 -: LEN_W] == len_ff;
      for (int i = 0; i < LABEL_CHARS; i++) begin
         if (LEN_W'(i) < len_ff && row_q[i*8 +: 8] != label_ff[i*8 +: 8]) match = 1'b0;
      end
   end

   assign store = (state_ff == CHECK) && !valid_q && (op_ff == OP_INSERT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         cap_ff       <= CAP_BITS'(CAP_RESET);
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) cap_ff <= csr_write_data;
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  op_ff    <= cmd_data[CMD_W-1];
                  hash_ff  <= cmd_data[CMD_W-2 -: 32];
                  len_ff   <= cmd_data[DATA_BITS+LBL_W +: LEN_W];
                  label_ff <= cmd_data[DATA_BITS +: LBL_W];
                  data_ff  <= cmd_data[DATA_BITS-1:0];
                  rem_ff   <= '0;
                  bit_ff   <= '0;
                  state_ff <= DIV;
               end
            end
            DIV: begin
               rem_ff  <= rem_in;
               hash_ff <= hash_ff << 1;
               bit_ff  <= bit_ff + 5'd1;
               if (bit_ff == 5'd31) begin
                  pos_ff   <= IDX_W'(rem_in);
                  probe_ff <= '0;
                  state_ff <= READ;
               end
            end
            READ: begin
               state_ff <= CHECK;
            end
            CHECK: begin
               if (!valid_q) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= (op_ff == OP_INSERT) ? ST_INSERTED : ST_NOT_FOUND;
                  slot_ff      <= (op_ff == OP_INSERT) ? 8'(pos_ff) : 8'd0;
                  if (op_ff == OP_INSERT) valid_ff[pos_ff] <= 1'b1;
                  state_ff     <= IDLE;
               end else if (match) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= (op_ff == OP_INSERT) ? ST_DUPLICATE : ST_FOUND;
                  slot_ff      <= (op_ff == OP_INSERT) ? 8'd0 : 8'(pos_ff);
                  state_ff     <= IDLE;
               end else if (probe_in == cap_eff) begin
                  rsp_valid_ff <= 1'b1;
                  status_ff    <= (op_ff == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
                  slot_ff      <= 8'd0;
                  state_ff     <= IDLE;
               end else begin
                  probe_ff <= probe_in;
                  pos_ff   <= pos_in;
                  state_ff <= READ;
               end
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   // slot store: registered read at the current probe position
   always_ff @(posedge clock) begin
      row_q   <= row_mem[pos_ff];
      valid_q <= valid_ff[pos_ff];
      if (store) begin
         row_mem[pos_ff]  <= {len_ff, label_ff};
         data_mem[pos_ff] <= data_ff;
      end
   end

endmodule
`default_nettype wire

[rtl/lhtlp_checker.sv]
// Port-level checks for the label hash table, bound to the top level.
// Depends on lhtlp_pkg and label_hash_table_linear_probe.
`timescale 1ns / 1ps
`default_nettype none
module lhtlp_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_status,
   input logic [7:0] rsp_slot_index
);
   import lhtlp_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result beat dropped before it was taken");

   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result shown right after reset");

   a_fail_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_DUPLICATE || rsp_status == ST_FULL ||
                    rsp_status == ST_NOT_FOUND) |-> rsp_slot_index == 8'd0)
      else $error("failed command carries a slot");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= ST_NOT_FOUND)
      else $error("status code out of range");

endmodule

bind label_hash_table_linear_probe lhtlp_checker u_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_status     (rsp_status),
   .rsp_slot_index (rsp_slot_index)
);
`default_nettype wire

[verif/label_hash_table_linear_probe_checker.sv]
// Checker for the label hash table: watches the request, response and csr ports,
// predicts each command's result and compares it. Depends on lhtlp_pkg.
`timescale 1ns / 1ps
module label_hash_table_linear_probe_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic                           req_op,
   input  logic [7:0]                     req_label_byte,
   input  logic                           req_label_last,
   input  logic [31:0]                    req_entry_data,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [2:0]                     rsp_status,
   input  logic [7:0]                     rsp_slot_index,
   input  logic                           csr_write_enable,
   input  logic [lhtlp_pkg::CAP_BITS-1:0] csr_write_data,
   output int                             fail_count,
   output int                             pending
);
   import lhtlp_pkg::*;

   localparam int DEPTH = TABLE_DEPTH_DEF;
   localparam int CHARS = LABEL_CHARS_DEF;

   typedef struct packed {
      logic [2:0] status;
      logic [7:0] slot;
   } lookup_result_type;

   lookup_result_type   lookup_results[$];

   logic [CAP_BITS-1:0] capacity;
   logic                occupied[DEPTH];
   logic [7:0]          stored_label[DEPTH][CHARS];
   int                  stored_length[DEPTH];
   logic [31:0]         stored_data[DEPTH];
   logic [7:0]          label_bytes[CHARS];
   int                  label_fill;
   logic [31:0]         running_hash;

   task automatic report(input string what, input lookup_result_type want,
                         input lookup_result_type got);
      $display("%0t mismatch in %s: expected status %0d slot %0d, got status %0d slot %0d",
               $realtime, what, want.status, want.slot, got.status, got.slot);
      fail_count++;
   endtask

   function automatic bit label_matches(input int slot);
      if (stored_length[slot] != label_fill)
         return 0;
      for (int i = 0; i < label_fill; i++)
         if (stored_label[slot][i] != label_bytes[i])
            return 0;
      return 1;
   endfunction

   // Run one command against the shadow table and return its result.
   function automatic lookup_result_type run_command(input logic op,
                                                     input logic [31:0] data);
      lookup_result_type res;
      int             cap;
      int             pos;
      bit             done;
      cap = capacity;
      if (cap == 0)
         cap = 1;
      if (cap > DEPTH)
         cap = DEPTH;
      pos = running_hash % cap;
      res.status = (op == OP_INSERT) ? ST_FULL : ST_NOT_FOUND;
      res.slot = 8'd0;
      done = 0;
      for (int probe = 0; probe < cap && !done; probe++) begin
         if (!occupied[pos]) begin
            if (op == OP_INSERT) begin
               occupied[pos] = 1'b1;
               for (int i = 0; i < label_fill; i++)
                  stored_label[pos][i] = label_bytes[i];
               stored_length[pos] = label_fill;
               stored_data[pos] = data;
               res.status = ST_INSERTED;
               res.slot = pos[7:0];
            end
            done = 1;
         end else if (label_matches(pos)) begin
            if (op == OP_INSERT) begin
               res.status = ST_DUPLICATE;
            end else begin
               res.status = ST_FOUND;
               res.slot = pos[7:0];
            end
            done = 1;
         end else begin
            pos = (pos + 1 == cap) ? 0 : pos + 1;
         end
      end
      return res;
   endfunction

   initial begin
      fail_count = 0;
   end

   assign pending = lookup_results.size();

   always @(posedge clock) begin
      lookup_result_type got;
      lookup_result_type want;
      if (reset) begin
         capacity <= CAP_BITS'(CAP_RESET);
         for (int i = 0; i < DEPTH; i++)
            occupied[i] = 1'b0;
         label_fill = 0;
         running_hash = 0;
         lookup_results.delete();
      end else begin
         if (csr_write_enable)
            capacity <= csr_write_data;
         if (req_valid && req_ready) begin
            if (label_fill < CHARS) begin
               label_bytes[label_fill] = req_label_byte;
               label_fill++;
               running_hash = running_hash * 32'd7 + req_label_byte;
            end
            if (req_label_last) begin
               lookup_results.push_back(run_command(req_op, req_entry_data));
               label_fill = 0;
               running_hash = 0;
            end
         end
         if (rsp_valid && rsp_ready) begin
            got.status = rsp_status;
            got.slot = rsp_slot_index;
            if (lookup_results.size() == 0) begin
               want = '0;
               report("unexpected response", want, got);
            end else begin
               want = lookup_results.pop_front();
               if (got.status != want.status)
                  report("status", want, got);
               else if (got.slot != want.slot)
                  report("slot_index", want, got);
            end
         end
      end
   end

   final begin
   end

endmodule

[verif/label_hash_table_linear_probe_test.sv]
// Testbench top for the label hash table: clock, reset, stimulus and verdict.
// Depends on lhtlp_pkg, label_hash_table_linear_probe and its checker.
`timescale 1ns / 1ps
module label_hash_table_linear_probe_test;
   import lhtlp_pkg::*;

   localparam int POOL = 24;
   localparam int MAX_LEN = 40;
   localparam int CYCLE_LIMIT = 3000000;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic                req_op;
   logic [7:0]          req_label_byte;
   logic                req_label_last;
   logic [31:0]         req_entry_data;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [2:0]          rsp_status;
   logic [7:0]          rsp_slot_index;
   logic                csr_write_enable;
   logic [CAP_BITS-1:0] csr_write_data;
   int                  fail_count;
   int                  pending;

   logic [7:0] pool_bytes[POOL][MAX_LEN];
   int         pool_length[POOL];
   logic [7:0] fresh_bytes[MAX_LEN];
   int         beats_sent;
   int         commands_sent;
   int         settings_used;
   int         cycle_count;
   bit         park_request;
   int         park_left;

   label_hash_table_linear_probe DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_label_byte(req_label_byte), .req_label_last(req_label_last),
      .req_entry_data(req_entry_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data)
   );

   label_hash_table_linear_probe_checker u_checker (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_op(req_op),
      .req_label_byte(req_label_byte), .req_label_last(req_label_last),
      .req_entry_data(req_entry_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_status(rsp_status),
      .rsp_slot_index(rsp_slot_index),
      .csr_write_enable(csr_write_enable), .csr_write_data(csr_write_data),
      .fail_count(fail_count), .pending(pending)
   );

   initial clock = 0;
   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAIL label_hash_table_linear_probe");
         $finish;
      end
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Response side: random backpressure, or a long counted park on request.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
         park_left <= 0;
      end else if (park_request && park_left == 0) begin
         park_left <= 400;
         park_request <= 0;
         rsp_ready <= 0;
      end else if (park_left > 0) begin
         park_left <= park_left - 1;
         rsp_ready <= (park_left == 1);
      end else begin
         rsp_ready <= ($urandom_range(0, 99) < 70) || ($urandom_range(0, 9) == 0);
      end
   end

   task automatic idle_gap(input int n);
      if (n > 0) begin
         req_valid <= 0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic send_beat(input logic op, input logic [7:0] b, input logic last,
                            input logic [31:0] data);
      req_valid <= 1;
      req_op <= op;
      req_label_byte <= b;
      req_label_last <= last;
      req_entry_data <= data;
      do @(posedge clock); while (!req_ready);
      beats_sent++;
      idle_gap(pick_gap());
   endtask

   // Stream one label; op and data on the leading beats are don't-care noise.
   task automatic send_label(input logic [7:0] bytes[MAX_LEN], input int len,
                             input logic op, input logic [31:0] data);
      for (int i = 0; i < len; i++) begin
         if (i == len - 1)
            send_beat(op, bytes[i], 1, data);
         else
            send_beat(1'($urandom_range(0, 1)), bytes[i], 0, $urandom);
      end
      commands_sent++;
   endtask

   // Drop valid so the last beat is not offered again, then wait out all results.
   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      wait (pending == 0);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_capacity(input int value);
      drain();
      csr_write_enable <= 1;
      csr_write_data <= CAP_BITS'(value);
      @(posedge clock);
      csr_write_enable <= 0;
      settings_used++;
   endtask

   task automatic random_phase(input int beats);
      int target;
      int idx;
      int len;
      target = beats_sent + beats;
      while (beats_sent < target) begin
         if ($urandom_range(0, 99) < 70) begin
            idx = $urandom_range(0, POOL - 1);
            send_label(pool_bytes[idx], pool_length[idx], 1'($urandom_range(0, 1)),
                       $urandom);
         end else begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(30, MAX_LEN)
                                              : $urandom_range(1, 5);
            for (int i = 0; i < len; i++)
               fresh_bytes[i] = 8'($urandom_range(1, 255));
            send_label(fresh_bytes, len, 1'($urandom_range(0, 1)), $urandom);
         end
      end
   endtask

   initial begin
      logic [7:0] lbl[MAX_LEN];
      cycle_count = 0;
      beats_sent = 0;
      commands_sent = 0;
      settings_used = 0;
      park_request = 0;
      reset = 1;
      req_valid = 0;
      req_op = 0;
      req_label_byte = 8'd1;
      req_label_last = 0;
      req_entry_data = 0;
      csr_write_enable = 0;
      csr_write_data = 0;
      for (int p = 0; p < POOL; p++) begin
         // A few pool labels are over-long and differ only past the stored prefix.
         pool_length[p] = (p < 3) ? 33 + p : $urandom_range(1, 6);
         for (int i = 0; i < MAX_LEN; i++)
            pool_bytes[p][i] = (p < 3 && i < 32) ? 8'h41 : 8'($urandom_range(1, 255));
      end
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: byte extremes, both ops, duplicate, hit, miss, zero byte.
      lbl[0] = 8'd1;
      send_label(lbl, 1, OP_FIND, 32'd0);
      send_label(lbl, 1, OP_INSERT, 32'd0);
      send_label(lbl, 1, OP_INSERT, 32'hFFFF_FFFF);
      send_label(lbl, 1, OP_FIND, 32'd0);
      lbl[0] = 8'd255; lbl[1] = 8'd255; lbl[2] = 8'd255;
      send_label(lbl, 3, OP_INSERT, 32'hFFFF_FFFF);
      send_label(lbl, 3, OP_FIND, 32'd0);
      send_label(lbl, 2, OP_FIND, 32'd0);
      lbl[0] = 8'd0; lbl[1] = 8'd128;
      send_label(lbl, 2, OP_INSERT, 32'h8000_0001);
      send_label(lbl, 2, OP_FIND, 32'd0);
      lbl[0] = 8'd127;
      send_label(lbl, 1, OP_INSERT, 32'h7FFF_FFFF);

      random_phase(200);
      write_capacity(1);
      random_phase(120);
      write_capacity(0);
      random_phase(100);
      write_capacity(3);
      park_request = 1;
      random_phase(150);
      write_capacity(511);
      random_phase(200);
      drain();
      random_phase(150);
      write_capacity(17);
      random_phase(200);
      write_capacity(300);
      random_phase(200);
      write_capacity(256);
      random_phase(180);

      idle_gap(1);
      drain();
      repeat (600) @(posedge clock);
      $display("Sent %0d label beats forming %0d commands across %0d capacity writes,",
               beats_sent, commands_sent, settings_used);
      $display("with random backpressure and one long response stall; %0d mismatches.",
               fail_count);
      if (fail_count == 0)
         $display("PASS label_hash_table_linear_probe");
      else
         $display("FAIL label_hash_table_linear_probe");
      $finish;
   end

endmodule

[filelist.f]
rtl/lhtlp_pkg.sv
rtl/lhtlp_front.sv
rtl/lhtlp_queue.sv
rtl/lhtlp_back.sv
rtl/label_hash_table_linear_probe.sv
rtl/lhtlp_checker.sv
verif/label_hash_table_linear_probe_checker.sv
verif/label_hash_table_linear_probe_test.sv
